[rtl/core/sma_pkg.sv]
// Package of opcodes, error codes and shared types for the stack machine ALU.
package sma_pkg;

    typedef enum logic [4:0] {
        OP_PUSH  = 5'd0,  OP_DROP = 5'd1,  OP_DUP  = 5'd2,  OP_SWAP = 5'd3,
        OP_ROT3  = 5'd4,  OP_ADD  = 5'd5,  OP_SUB  = 5'd6,  OP_MUL  = 5'd7,
        OP_DIV   = 5'd8,  OP_MOD  = 5'd9,  OP_AND  = 5'd10, OP_OR   = 5'd11,
        OP_XOR   = 5'd12, OP_NOT  = 5'd13, OP_SHL  = 5'd14, OP_SHR  = 5'd15,
        OP_POW   = 5'd16, OP_LT   = 5'd17, OP_GT   = 5'd18, OP_EQ   = 5'd19,
        OP_LAND  = 5'd20, OP_LOR  = 5'd21, OP_LNOT = 5'd22, OP_DEPTH = 5'd23
    } op_t;

    localparam logic [2:0] ERR_OK     = 3'd0;
    localparam logic [2:0] ERR_OVER   = 3'd1;
    localparam logic [2:0] ERR_UNDER  = 3'd2;
    localparam logic [2:0] ERR_DIVZ   = 3'd3;
    localparam logic [2:0] ERR_NEGEXP = 3'd4;

    // Operation codes of the shared iterative unit.
    typedef enum logic [1:0] {
        IU_MUL = 2'd0,
        IU_DIV = 2'd1,
        IU_POW = 2'd2
    } iu_op_t;

    // Request to the iterative unit.
    typedef struct packed {
        logic   start;
        iu_op_t op;
    } iu_req_t;

    // Number of operands that each opcode takes from the stack.
    function automatic logic [1:0] need_of(input logic [4:0] op);
        logic [1:0] n;
        case (op)
            OP_PUSH, OP_DEPTH:          n = 2'd0;
            OP_DROP, OP_DUP, OP_NOT,
            OP_LNOT:                    n = 2'd1;
            OP_ROT3:                    n = 2'd3;
            default:                    n = 2'd2;
        endcase
        return n;
    endfunction

endpackage

[rtl/core/sma_iter_unit.sv]
// Shared iterative unit: shift-add multiply, restoring divide and square-multiply power.
module sma_iter_unit
    import sma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  iu_req_t     req,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] quo,
    output logic [63:0] rem
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_POWMUL,
        S_DONE
    } state_t;

    state_t      state_reg;
    iu_op_t      op_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] acc_reg;
    logic [63:0] x_reg;
    logic [63:0] y_reg;
    logic [63:0] r_reg;
    logic        na_reg;
    logic        nb_reg;
    logic        pm_sq_reg;

    logic [64:0] trial;
    logic [63:0] sum;

    // One step: a trial subtraction for divide, an add for multiply.
    assign trial = {r_reg, x_reg[63]} - {1'b0, y_reg};
    assign sum   = acc_reg + (y_reg[0] ? x_reg : 64'd0);

    // Power uses a small inner shift-add multiply for each product.
    logic [63:0] pm_acc_reg;
    logic [63:0] pm_x_reg;
    logic [63:0] pm_y_reg;
    logic [6:0]  pm_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        op_reg  <= req.op;
                        cnt_reg <= 7'd64;
                        r_reg   <= 64'd0;
                        na_reg  <= a[63];
                        nb_reg  <= b[63];
                        unique case (req.op)
                            IU_DIV:
                            begin
                                x_reg <= a[63] ? (64'd0 - a) : a;
                                y_reg <= b[63] ? (64'd0 - b) : b;
                            end
                            IU_POW:
                            begin
                                acc_reg <= 64'd1;
                                x_reg   <= a;
                                y_reg   <= b;
                            end
                            default:
                            begin
                                acc_reg <= 64'd0;
                                x_reg   <= a;
                                y_reg   <= b;
                            end
                        endcase
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    unique case (op_reg)
                        IU_DIV:
                        begin
                            if (!trial[64])
                                r_reg <= trial[63:0];
                            else
                                r_reg <= {r_reg[62:0], x_reg[63]};
                            x_reg   <= {x_reg[62:0], ~trial[64]};
                            cnt_reg <= cnt_reg - 7'd1;
                            if (cnt_reg == 7'd1)
                                state_reg <= S_DONE;
                        end
                        IU_POW:
                        begin
                            if (y_reg == 64'd0)
                                state_reg <= S_DONE;
                            else
                            begin
                                // Multiply by the base if the low bit is set, then square.
                                pm_sq_reg  <= ~y_reg[0];
                                pm_acc_reg <= 64'd0;
                                pm_x_reg   <= y_reg[0] ? acc_reg : x_reg;
                                pm_y_reg   <= x_reg;
                                pm_cnt_reg <= 7'd64;
                                state_reg  <= S_POWMUL;
                            end
                        end
                        default:
                        begin
                            acc_reg <= sum;
                            x_reg   <= {x_reg[62:0], 1'b0};
                            y_reg   <= {1'b0, y_reg[63:1]};
                            cnt_reg <= cnt_reg - 7'd1;
                            if (cnt_reg == 7'd1 || y_reg[63:1] == 63'd0)
                                state_reg <= S_DONE;
                        end
                    endcase
                end
                S_POWMUL:
                begin
                    if (pm_cnt_reg == 7'd0 || pm_y_reg == 64'd0)
                    begin
                        if (pm_sq_reg)
                        begin
                            x_reg     <= pm_acc_reg;
                            y_reg     <= {1'b0, y_reg[63:1]};
                            state_reg <= S_RUN;
                        end
                        else
                        begin
                            acc_reg    <= pm_acc_reg;
                            pm_sq_reg  <= 1'b1;
                            pm_acc_reg <= 64'd0;
                            pm_x_reg   <= x_reg;
                            pm_y_reg   <= x_reg;
                            pm_cnt_reg <= 7'd64;
                        end
                    end
                    else
                    begin
                        pm_acc_reg <= pm_acc_reg + (pm_y_reg[0] ? pm_x_reg : 64'd0);
                        pm_x_reg   <= {pm_x_reg[62:0], 1'b0};
                        pm_y_reg   <= {1'b0, pm_y_reg[63:1]};
                        pm_cnt_reg <= pm_cnt_reg - 7'd1;
                    end
                end
                S_DONE:
                begin
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Sign correction of truncating division; multiply and power return the accumulator.
    always_comb
    begin
        if (op_reg == IU_DIV)
        begin
            quo = (na_reg != nb_reg) ? (64'd0 - x_reg) : x_reg;
            rem = na_reg ? (64'd0 - r_reg) : r_reg;
        end
        else
        begin
            quo = acc_reg;
            rem = 64'd0;
        end
    end

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("iterative unit done held for two cycles");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.start && state_reg == S_IDLE) |=> state_reg == S_RUN)
        else $error("iterative unit ignored a start");
    a_done_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_DONE)
        else $error("done raised outside the done state");

endmodule

[rtl/core/stack_machine_alu.sv]
// Top level of the stack machine ALU: sequencer, stack memory and result register.
//
// Usage: one request on the input channel (opcode, immediate) produces one
// result on the output channel (top_value, stack_depth, error_code).
// The block takes one request at a time; in_ready is low from acceptance
// until the result has been taken by the receiver.
// Steps: each request takes three operand reads from the stack memory's
// single read port, an execute step, then write-back and a fresh read of
// the new top; swap and reversal of the top three add a second write.
// Multiply runs through the shared shift-add unit, divide and modulo
// through its restoring divider at one quotient bit per cycle, and pow
// through its square-and-multiply loop over the exponent bits.
// The next request can be accepted once the result has been taken and
// the sequencer is back in idle.
// Reset clears the stack pointer and the control state; the stack memory
// is not cleared, and unwritten entries may be read but are never used.
// A stalled receiver simply holds the result in the output register; no
// new request is accepted until it is taken.
module stack_machine_alu
    import sma_pkg::*;
#(
    parameter int STACK_SIZE = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  opcode,
    input  logic signed [63:0] immediate,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [63:0] top_value,
    output logic [9:0]  stack_depth,
    output logic [2:0]  error_code
);

    localparam int AW = $clog2(STACK_SIZE);
    localparam int PW = $clog2(STACK_SIZE + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_RD3,
        S_EXEC,
        S_WAIT,
        S_WR2,
        S_TOP,
        S_TOPR,
        S_TOPW,
        S_OUT
    } state_t;

    state_t      state_reg;
    logic [4:0]  op_reg;
    logic [63:0] imm_reg;
    logic [PW-1:0] sp_reg;
    logic [63:0] b_reg;
    logic [63:0] a_reg;
    logic [63:0] c_reg;
    logic [63:0] res_reg;
    logic [2:0]  err_reg;

    // Stack memory with one registered read port.
    logic [63:0] mem [STACK_SIZE];
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic [63:0]   rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    iu_req_t     iu_req;
    logic        iu_done;
    logic [63:0] iu_quo;
    logic [63:0] iu_rem;

    sma_iter_unit u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (iu_req),
        .a     (a_reg),
        .b     (b_reg),
        .done  (iu_done),
        .quo   (iu_quo),
        .rem   (iu_rem)
    );

    logic [PW-1:0] sp_m1;
    logic [PW-1:0] sp_m2;
    logic [PW-1:0] sp_m3;
    logic [PW-1:0] sp_p1;
    assign sp_m1 = sp_reg - PW'(1);
    assign sp_m2 = sp_reg - PW'(2);
    assign sp_m3 = sp_reg - PW'(3);
    assign sp_p1 = sp_reg + PW'(1);

    logic under;
    logic over;
    assign under = sp_reg < PW'(need_of(op_reg));
    assign over  = (op_reg == OP_PUSH || op_reg == OP_DUP || op_reg == OP_DEPTH)
                   && ({1'b0, sp_p1} >= (PW + 1)'(STACK_SIZE));

    logic [63:0] alu_res;
    logic        slt_ab;
    logic        slt_ba;
    assign slt_ab = $signed(a_reg) < $signed(b_reg);
    assign slt_ba = $signed(b_reg) < $signed(a_reg);

    // Combinational results of binary ops.
    always_comb
    begin
        case (op_reg)
            OP_ADD:  alu_res = a_reg + b_reg;
            OP_SUB:  alu_res = a_reg - b_reg;
            OP_AND:  alu_res = a_reg & b_reg;
            OP_OR:   alu_res = a_reg | b_reg;
            OP_XOR:  alu_res = a_reg ^ b_reg;
            OP_SHL:  alu_res = a_reg << b_reg[5:0];
            OP_SHR:  alu_res = 64'($signed(a_reg) >>> b_reg[5:0]);
            OP_LT:   alu_res = {63'd0, slt_ab};
            OP_GT:   alu_res = {63'd0, slt_ba};
            OP_EQ:   alu_res = {63'd0, a_reg == b_reg};
            OP_LAND: alu_res = {63'd0, (a_reg != 64'd0) && (b_reg != 64'd0)};
            OP_LOR:  alu_res = {63'd0, (a_reg != 64'd0) || (b_reg != 64'd0)};
            default: alu_res = 64'd0;
        endcase
    end

    // Read address follows the state that is about to load operands.
    always_comb
    begin
        unique case (state_reg)
            S_RD1:   rd_addr = AW'(sp_m2);
            S_RD2:   rd_addr = AW'(sp_m3);
            default: rd_addr = AW'(sp_m1);
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    // Sequencer: read operands, execute, write back, read the new top.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
            out_valid <= 1'b0;
            wr_en     <= 1'b0;
            iu_req    <= '0;
        end
        else
        begin
            wr_en        <= 1'b0;
            iu_req.start <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= opcode;
                        imm_reg   <= immediate;
                        err_reg   <= ERR_OK;
                        state_reg <= S_RD1;
                    end
                end
                S_RD1:
                begin
                    b_reg     <= rd_data_reg;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    a_reg     <= rd_data_reg;
                    state_reg <= S_RD3;
                end
                S_RD3:
                begin
                    c_reg     <= rd_data_reg;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_TOP;
                    if (op_reg > OP_DEPTH)
                        err_reg <= ERR_OK;
                    else if (under)
                        err_reg <= ERR_UNDER;
                    else if (over)
                        err_reg <= ERR_OVER;
                    else
                    begin
                        case (op_reg)
                            OP_PUSH:
                            begin
                                wr_en   <= 1'b1;
                                wr_addr <= AW'(sp_reg);
                                wr_data <= imm_reg;
                                sp_reg  <= sp_p1;
                            end
                            OP_DUP:
                            begin
                                wr_en   <= 1'b1;
                                wr_addr <= AW'(sp_reg);
                                wr_data <= b_reg;
                                sp_reg  <= sp_p1;
                            end
                            OP_DEPTH:
                            begin
                                wr_en   <= 1'b1;
                                wr_addr <= AW'(sp_reg);
                                wr_data <= 64'(sp_reg);
                                sp_reg  <= sp_p1;
                            end
                            OP_DROP:
                                sp_reg <= sp_m1;
                            OP_SWAP:
                            begin
                                wr_en     <= 1'b1;
                                wr_addr   <= AW'(sp_m1);
                                wr_data   <= a_reg;
                                res_reg   <= b_reg;
                                state_reg <= S_WR2;
                            end
                            OP_ROT3:
                            begin
                                wr_en     <= 1'b1;
                                wr_addr   <= AW'(sp_m1);
                                wr_data   <= c_reg;
                                res_reg   <= b_reg;
                                state_reg <= S_WR2;
                            end
                            OP_NOT:
                            begin
                                wr_en   <= 1'b1;
                                wr_addr <= AW'(sp_m1);
                                wr_data <= ~b_reg;
                            end
                            OP_LNOT:
                            begin
                                wr_en   <= 1'b1;
                                wr_addr <= AW'(sp_m1);
                                wr_data <= {63'd0, b_reg == 64'd0};
                            end
                            OP_MUL:
                            begin
                                iu_req    <= '{start: 1'b1, op: IU_MUL};
                                state_reg <= S_WAIT;
                            end
                            OP_DIV, OP_MOD:
                            begin
                                if (b_reg == 64'd0)
                                    err_reg <= ERR_DIVZ;
                                else
                                begin
                                    iu_req    <= '{start: 1'b1, op: IU_DIV};
                                    state_reg <= S_WAIT;
                                end
                            end
                            OP_POW:
                            begin
                                if (b_reg[63])
                                    err_reg <= ERR_NEGEXP;
                                else
                                begin
                                    iu_req    <= '{start: 1'b1, op: IU_POW};
                                    state_reg <= S_WAIT;
                                end
                            end
                            default:
                            begin
                                wr_en   <= 1'b1;
                                wr_addr <= AW'(sp_m2);
                                wr_data <= alu_res;
                                sp_reg  <= sp_m1;
                            end
                        endcase
                    end
                end
                S_WAIT:
                begin
                    if (iu_done)
                    begin
                        wr_en     <= 1'b1;
                        wr_addr   <= AW'(sp_m2);
                        wr_data   <= (op_reg == OP_MOD) ? iu_rem : iu_quo;
                        sp_reg    <= sp_m1;
                        state_reg <= S_TOP;
                    end
                end
                S_WR2:
                begin
                    // Second write of swap or reversal of the top three.
                    wr_en     <= 1'b1;
                    wr_addr   <= (op_reg == OP_SWAP) ? AW'(sp_m2) : AW'(sp_m3);
                    wr_data   <= res_reg;
                    state_reg <= S_TOP;
                end
                S_TOP:
                begin
                    // The last write lands at the end of this cycle.
                    state_reg <= S_TOPR;
                end
                S_TOPR:
                begin
                    // The new top is read from memory at the end of this cycle.
                    state_reg <= S_TOPW;
                end
                S_TOPW:
                begin
                    top_value   <= (sp_reg != '0) ? rd_data_reg : 64'd0;
                    stack_depth <= 10'(sp_reg);
                    error_code  <= err_reg;
                    out_valid   <= 1'b1;
                    state_reg   <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, sp_reg} < (PW + 1)'(STACK_SIZE)))
        else $error("stack pointer beyond capacity");
    a_err_keeps_sp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && !(op_reg > OP_DEPTH) && (under || over)) |=> $stable(sp_reg))
        else $error("stack changed on an error");
    a_valid_only_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT)
        else $error("result shown outside the output state");
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WAIT |-> !in_ready)
        else $error("ready while the iterative unit runs");

endmodule
